FILE: design/frame_receiver_with_checksum_unit_macros.svh
// Assertion helpers for the frame receiver.
`ifndef FRAME_RECEIVER_WITH_CHECKSUM_UNIT_MACROS_SVH
`define FRAME_RECEIVER_WITH_CHECKSUM_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FRC_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("frame receiver check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FRC_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("frame receiver check failed");

`endif

FILE: design/frc_pkg.sv
package frc_pkg;

    localparam logic [7:0] START_BYTE = 8'h0A;
    localparam logic [7:0] END_BYTE   = 8'h0D;

    // frame length limits, start and end bytes included
    localparam logic [8:0] FRAME_LIMIT_MIN   = 9'd4;
    localparam logic [8:0] FRAME_LIMIT_MAX   = 9'd256;
    localparam logic [8:0] FRAME_LIMIT_RESET = 9'd256;

    // checksum values below this are raised by it
    localparam logic [7:0] CHECK_FLOOR = 8'd32;

    typedef enum logic [1:0] {
        CFG_MANUAL_MODE = 2'd0,
        CFG_SKIP_CHECK  = 2'd1,
        CFG_ECHO_ENABLE = 2'd2,
        CFG_FRAME_LIMIT = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_SUM  = 2'd1,
        STATUS_NO_START = 2'd2,
        STATUS_OVERRUN  = 2'd3
    } frame_status_t;

endpackage

FILE: design/frame_receiver_with_checksum_unit.sv
// A result word appears on the output register in the cycle after its input word.
// Throughput: one byte per cycle while the output register is not stalled; the input is
// taken whenever the output register is empty or is being drained in the same cycle.
// Reset (rst_n, async, active low) clears frame state and the output valid, and sets the
// registers to auto mode, checking on, echo off and a frame limit of 256.
`include "frame_receiver_with_checksum_unit_macros.svh"

module frame_receiver_with_checksum_unit
(
    input  logic       clk,
    input  logic       rst_n,

    // configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data,

    // received line bytes
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,

    // one result word per received byte
    output logic       out_valid,
    input  logic       out_ready,
    output logic       payload_valid,
    output logic [7:0] payload_byte,
    output logic       frame_done,
    output logic [1:0] frame_status,
    output logic [8:0] payload_length,
    output logic       echo_valid,
    output logic [7:0] echo_byte
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; the user writes
    // only while the block is idle.
    // ------------------------------------------------------------------
    logic       manual_mode_reg;
    logic       skip_check_reg;
    logic       echo_enable_reg;
    logic [8:0] frame_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            manual_mode_reg <= 1'b0;
            skip_check_reg  <= 1'b0;
            echo_enable_reg <= 1'b0;
            frame_limit_reg <= frc_pkg::FRAME_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (frc_pkg::cfg_index_t'(cfg_index))
                frc_pkg::CFG_MANUAL_MODE: manual_mode_reg <= cfg_data[0];
                frc_pkg::CFG_SKIP_CHECK:  skip_check_reg  <= cfg_data[0];
                frc_pkg::CFG_ECHO_ENABLE: echo_enable_reg <= cfg_data[0];
                frc_pkg::CFG_FRAME_LIMIT: frame_limit_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Frame state
    // ------------------------------------------------------------------
    logic       in_frame_reg,      in_frame_next;
    logic       start_missing_reg, start_missing_next;
    logic [8:0] byte_count_reg,    byte_count_next;
    logic [7:0] held_byte_reg,     held_byte_next;
    logic       held_valid_reg,    held_valid_next;
    logic [7:0] running_sum_reg,   running_sum_next;
    logic [8:0] payload_count_reg, payload_count_next;

    // result word under construction
    logic       payload_valid_next;
    logic [7:0] payload_byte_next;
    logic       frame_done_next;
    logic [1:0] frame_status_next;
    logic [8:0] payload_length_next;
    logic       echo_valid_next;
    logic [7:0] echo_byte_next;

    // output register
    logic       out_valid_reg;
    logic       payload_valid_reg;
    logic [7:0] payload_byte_reg;
    logic       frame_done_reg;
    logic [1:0] frame_status_reg;
    logic [8:0] payload_length_reg;
    logic       echo_valid_reg;
    logic [7:0] echo_byte_reg;

    logic       in_accept;
    logic [8:0] limit;          // frame limit clamped to its legal range
    logic [9:0] next_count;     // byte number of the current byte
    logic [7:0] expect_sum;     // checksum the sender should have sent
    logic [8:0] count_plus_one;

    // take a new byte when the output register is free or drains now
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        if (frame_limit_reg < frc_pkg::FRAME_LIMIT_MIN)
            limit = frc_pkg::FRAME_LIMIT_MIN;
        else if (frame_limit_reg > frc_pkg::FRAME_LIMIT_MAX)
            limit = frc_pkg::FRAME_LIMIT_MAX;
        else
            limit = frame_limit_reg;
    end

    assign next_count     = {1'b0, byte_count_reg} + 10'd1;
    assign expect_sum     = (running_sum_reg < frc_pkg::CHECK_FLOOR)
                          ? running_sum_reg + frc_pkg::CHECK_FLOOR
                          : running_sum_reg;
    assign count_plus_one = payload_count_reg + 9'd1;

    always_comb
    begin
        in_frame_next      = in_frame_reg;
        start_missing_next = start_missing_reg;
        byte_count_next    = byte_count_reg;
        held_byte_next     = held_byte_reg;
        held_valid_next    = held_valid_reg;
        running_sum_next   = running_sum_reg;
        payload_count_next = payload_count_reg;

        payload_valid_next  = 1'b0;
        payload_byte_next   = 8'd0;
        frame_done_next     = 1'b0;
        frame_status_next   = frc_pkg::STATUS_OK;
        payload_length_next = 9'd0;
        echo_valid_next     = echo_enable_reg;
        echo_byte_next      = echo_enable_reg ? rx_byte : 8'd0;

        if (rx_byte == frc_pkg::START_BYTE)
        begin
            // start byte: drop whatever was in progress and open a frame
            in_frame_next      = 1'b1;
            start_missing_next = 1'b0;
            byte_count_next    = 9'd1;
            held_byte_next     = 8'd0;
            held_valid_next    = 1'b0;
            running_sum_next   = 8'd0;
            payload_count_next = 9'd0;
        end
        else if (!in_frame_reg)
        begin
            if (rx_byte == frc_pkg::END_BYTE)
            begin
                frame_done_next   = 1'b1;
                frame_status_next = frc_pkg::STATUS_NO_START;
            end
            else
            begin
                // headless frame: counted for overrun, never released
                in_frame_next      = 1'b1;
                start_missing_next = 1'b1;
                byte_count_next    = 9'd1;
            end
        end
        else if (rx_byte == frc_pkg::END_BYTE)
        begin
            frame_done_next     = 1'b1;
            payload_length_next = start_missing_reg ? 9'd0 : payload_count_reg;
            if (start_missing_reg)
                frame_status_next = frc_pkg::STATUS_NO_START;
            else if (manual_mode_reg)
            begin
                // no checksum byte: the held byte is the last payload byte
                frame_status_next = frc_pkg::STATUS_OK;
                if (held_valid_reg)
                begin
                    payload_valid_next  = 1'b1;
                    payload_byte_next   = held_byte_reg;
                    payload_length_next = count_plus_one;
                end
            end
            else if (!held_valid_reg)
                frame_status_next = frc_pkg::STATUS_BAD_SUM;
            else if (!skip_check_reg && held_byte_reg != expect_sum)
                frame_status_next = frc_pkg::STATUS_BAD_SUM;
            else
                frame_status_next = frc_pkg::STATUS_OK;

            in_frame_next      = 1'b0;
            start_missing_next = 1'b0;
            byte_count_next    = 9'd0;
            held_byte_next     = 8'd0;
            held_valid_next    = 1'b0;
            running_sum_next   = 8'd0;
            payload_count_next = 9'd0;
        end
        else if (next_count >= {1'b0, limit})
        begin
            // frame too long: abort, nothing released
            frame_done_next     = 1'b1;
            frame_status_next   = frc_pkg::STATUS_OVERRUN;
            payload_length_next = start_missing_reg ? 9'd0 : payload_count_reg;
            in_frame_next       = 1'b0;
            start_missing_next  = 1'b0;
            byte_count_next     = 9'd0;
            held_byte_next      = 8'd0;
            held_valid_next     = 1'b0;
            running_sum_next    = 8'd0;
            payload_count_next  = 9'd0;
        end
        else
        begin
            byte_count_next = next_count[8:0];
            if (!start_missing_reg)
            begin
                // release the previous byte, hold this one
                if (held_valid_reg)
                begin
                    payload_valid_next = 1'b1;
                    payload_byte_next  = held_byte_reg;
                    // order digit (first payload byte) is not summed
                    if (!manual_mode_reg && payload_count_reg != 9'd0)
                        running_sum_next = running_sum_reg + held_byte_reg;
                    payload_count_next = count_plus_one;
                end
                held_byte_next  = rx_byte;
                held_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg      <= 1'b0;
            start_missing_reg <= 1'b0;
            byte_count_reg    <= 9'd0;
            held_byte_reg     <= 8'd0;
            held_valid_reg    <= 1'b0;
            running_sum_reg   <= 8'd0;
            payload_count_reg <= 9'd0;
        end
        else if (in_accept)
        begin
            in_frame_reg      <= in_frame_next;
            start_missing_reg <= start_missing_next;
            byte_count_reg    <= byte_count_next;
            held_byte_reg     <= held_byte_next;
            held_valid_reg    <= held_valid_next;
            running_sum_reg   <= running_sum_next;
            payload_count_reg <= payload_count_next;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // output payload, loaded only with a new word
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            payload_valid_reg  <= payload_valid_next;
            payload_byte_reg   <= payload_byte_next;
            frame_done_reg     <= frame_done_next;
            frame_status_reg   <= frame_status_next;
            payload_length_reg <= payload_length_next;
            echo_valid_reg     <= echo_valid_next;
            echo_byte_reg      <= echo_byte_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign payload_valid  = payload_valid_reg;
    assign payload_byte   = payload_byte_reg;
    assign frame_done     = frame_done_reg;
    assign frame_status   = frame_status_reg;
    assign payload_length = payload_length_reg;
    assign echo_valid     = echo_valid_reg;
    assign echo_byte      = echo_byte_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // outside a frame nothing is held or counted
    `FRC_ASSERT_NOW(a_idle_clean, !in_frame_reg, !held_valid_reg && payload_count_reg == 9'd0)
    // a headless frame never delivers a length
    `FRC_ASSERT_NOW(a_no_start_len, out_valid && frame_done && frame_status == frc_pkg::STATUS_NO_START, payload_length == 9'd0)
    // status and length only travel with frame end
    `FRC_ASSERT_NOW(a_status_quiet, out_valid && !frame_done, frame_status == frc_pkg::STATUS_OK && payload_length == 9'd0)
    // a start byte always opens a fresh frame
    `FRC_ASSERT_NEXT(a_start_opens, in_accept && rx_byte == frc_pkg::START_BYTE, in_frame_reg && byte_count_reg == 9'd1 && !held_valid_reg)

endmodule

FILE: sim/tb_frame_receiver_with_checksum_unit.sv
`timescale 1ns / 100ps

module tb_frame_receiver_with_checksum_unit;

    import frc_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    // one result word as the block presents it
    typedef struct packed {
        logic          payload_valid;
        logic [7:0]    payload_byte;
        logic          frame_done;
        frame_status_t frame_status;
        logic [8:0]    payload_length;
        logic          echo_valid;
        logic [7:0]    echo_byte;
    } frame_word_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;

    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index = CFG_MANUAL_MODE;
    logic [8:0] cfg_data = '0;

    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte = '0;

    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       frame_done;
    logic [1:0] frame_status;
    logic [8:0] payload_length;
    logic       echo_valid;
    logic [7:0] echo_byte;

    frame_receiver_with_checksum_unit uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .payload_valid  (payload_valid),
        .payload_byte   (payload_byte),
        .frame_done     (frame_done),
        .frame_status   (frame_status),
        .payload_length (payload_length),
        .echo_valid     (echo_valid),
        .echo_byte      (echo_byte)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Deframer shadow: register copies and frame state, reset values.
    // Registers follow accepted config writes; frame state follows every
    // accepted byte.
    // ------------------------------------------------------------------
    logic       mode_manual = 1'b0;
    logic       mode_skip   = 1'b0;
    logic       mode_echo   = 1'b0;
    logic [8:0] limit_reg   = FRAME_LIMIT_RESET;

    logic       fr_open      = 1'b0;   // inside a frame
    logic       fr_orphan    = 1'b0;   // frame opened without start byte
    logic [8:0] fr_count     = '0;     // bytes of frame so far, start included
    logic [7:0] fr_held      = '0;     // byte waiting one slot before release
    logic       fr_held_ok   = 1'b0;
    logic [7:0] fr_sum       = '0;     // running checksum after order digit
    logic [8:0] fr_delivered = '0;     // payload bytes released this frame

    frame_word_t due_words[$];         // predicted words not yet seen

    int  errors        = 0;
    int  bytes_sent    = 0;
    int  words_checked = 0;
    int  cfg_writes    = 0;
    int  cycles        = 0;
    int  status_count[4] = '{0, 0, 0, 0};
    bit  no_idle       = 1'b0;         // set: neither side idles
    int  stall_left    = 0;

    function automatic void drop_frame();
        fr_open      = 1'b0;
        fr_orphan    = 1'b0;
        fr_count     = '0;
        fr_held      = '0;
        fr_held_ok   = 1'b0;
        fr_sum       = '0;
        fr_delivered = '0;
    endfunction

    // held byte goes out; the order digit (first byte in auto mode) is not summed
    function automatic void release_held_byte(inout frame_word_t w);
        w.payload_valid = 1'b1;
        w.payload_byte  = fr_held;
        if (!mode_manual && fr_delivered != 0)
            fr_sum = fr_sum + fr_held;
        if (fr_delivered < 9'd511)
            fr_delivered = fr_delivered + 9'd1;
        fr_held_ok = 1'b0;
    endfunction

    // word the block must return for one received byte
    function automatic frame_word_t deframe_byte(input logic [7:0] b);
        frame_word_t w;
        logic [8:0]  lim;
        logic [8:0]  nxt;
        logic [7:0]  want_sum;
        w = '0;
        if (mode_echo)
        begin
            w.echo_valid = 1'b1;
            w.echo_byte  = b;
        end
        lim = limit_reg;
        if (lim < FRAME_LIMIT_MIN)
            lim = FRAME_LIMIT_MIN;
        else if (lim > FRAME_LIMIT_MAX)
            lim = FRAME_LIMIT_MAX;

        // start byte always restarts, partial frame is lost silently
        if (b == START_BYTE)
        begin
            drop_frame();
            fr_open  = 1'b1;
            fr_count = 9'd1;
            return w;
        end
        if (!fr_open)
        begin
            if (b == END_BYTE)
            begin
                w.frame_done   = 1'b1;
                w.frame_status = STATUS_NO_START;
            end
            else
            begin
                fr_open   = 1'b1;
                fr_orphan = 1'b1;
                fr_count  = 9'd1;
            end
            return w;
        end

        nxt = fr_count + 9'd1;
        if (b == END_BYTE)
        begin
            if (fr_orphan)
            begin
                w.frame_status = STATUS_NO_START;
            end
            else if (mode_manual)
            begin
                if (fr_held_ok)
                    release_held_byte(w);
                w.frame_status = STATUS_OK;
            end
            else
            begin
                want_sum = fr_sum;
                if (want_sum < CHECK_FLOOR)
                    want_sum = want_sum + CHECK_FLOOR;
                // a missing checksum byte fails even with checking off
                if (!fr_held_ok || (!mode_skip && fr_held != want_sum))
                    w.frame_status = STATUS_BAD_SUM;
                else
                    w.frame_status = STATUS_OK;
            end
            w.frame_done     = 1'b1;
            w.payload_length = fr_orphan ? 9'd0 : fr_delivered;
            drop_frame();
            return w;
        end
        if (nxt >= lim)
        begin
            w.frame_done     = 1'b1;
            w.frame_status   = STATUS_OVERRUN;
            w.payload_length = fr_orphan ? 9'd0 : fr_delivered;
            drop_frame();
            return w;
        end
        fr_count = nxt;
        if (!fr_orphan)
        begin
            if (fr_held_ok)
                release_held_byte(w);
            fr_held    = b;
            fr_held_ok = 1'b1;
        end
        return w;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("frame_receiver_with_checksum_unit test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side back-pressure: random stall bursts on out_ready
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Monitor: track config writes, predict each accepted byte, check
    // each accepted result word against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        frame_word_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MANUAL_MODE: mode_manual = cfg_data[0];
                    CFG_SKIP_CHECK:  mode_skip   = cfg_data[0];
                    CFG_ECHO_ENABLE: mode_echo   = cfg_data[0];
                    CFG_FRAME_LIMIT: limit_reg   = cfg_data;
                    default: ;
                endcase
                cfg_writes++;
            end
            if (in_valid && in_ready)
                due_words.push_back(deframe_byte(rx_byte));
            if (out_valid && out_ready)
            begin
                if (due_words.size() == 0)
                begin
                    $error("result word with no byte outstanding");
                    errors++;
                end
                else
                begin
                    want = due_words.pop_front();
                    words_checked++;
                    if (payload_valid !== want.payload_valid)
                    begin
                        $error("payload_valid: expected %0d, got %0d",
                               want.payload_valid, payload_valid);
                        errors++;
                    end
                    if (payload_byte !== want.payload_byte)
                    begin
                        $error("payload_byte: expected %0h, got %0h",
                               want.payload_byte, payload_byte);
                        errors++;
                    end
                    if (frame_done !== want.frame_done)
                    begin
                        $error("frame_done: expected %0d, got %0d",
                               want.frame_done, frame_done);
                        errors++;
                    end
                    if (frame_status !== want.frame_status)
                    begin
                        $error("frame_status: expected %0d, got %0d",
                               want.frame_status, frame_status);
                        errors++;
                    end
                    if (payload_length !== want.payload_length)
                    begin
                        $error("payload_length: expected %0d, got %0d",
                               want.payload_length, payload_length);
                        errors++;
                    end
                    if (echo_valid !== want.echo_valid)
                    begin
                        $error("echo_valid: expected %0d, got %0d",
                               want.echo_valid, echo_valid);
                        errors++;
                    end
                    if (echo_byte !== want.echo_byte)
                    begin
                        $error("echo_byte: expected %0h, got %0h",
                               want.echo_byte, echo_byte);
                        errors++;
                    end
                    if (want.frame_done)
                        status_count[want.frame_status]++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Byte sender. Called at a rising edge; returns at the edge that took
    // the word. in_valid stays high into the next call when there is no gap.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    // sender holds off until every predicted word has been taken
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (due_words.size() != 0);
    endtask

    // register write, only with the block idle
    task automatic write_reg(input cfg_index_t idx, input logic [8:0] val);
        wait_drained();
        repeat (2) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);   // let the monitor pick up the new value
    endtask

    // One frame with random content and a correct checksum, or a broken one:
    // noise burst, no start byte, bad checksum, or cut off before the end.
    // forced_len >= 0 gives a plain good frame of that body length.
    task automatic send_random_frame(input int forced_len);
        int         kind;
        int         n;
        int         i;
        logic [7:0] sum;
        logic [7:0] b;
        kind = (forced_len >= 0) ? 50 : $urandom_range(0, 99);
        if (kind < 8)
        begin
            // delimiter-heavy noise
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 3))
                    0: b = START_BYTE;
                    1: b = END_BYTE;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                send_byte(b);
            end
        end
        else
        begin
            if (forced_len >= 0)
                n = forced_len;
            else if ($urandom_range(0, 59) == 0)
                n = $urandom_range(245, 262);
            else
                n = $urandom_range(0, 12);
            if (kind >= 12)
                send_byte(START_BYTE);
            sum = '0;
            for (i = 0; i < n; i++)
            begin
                b = 8'($urandom_range(0, 255));
                // stray delimiters inside the body are kept only rarely
                if ((b == START_BYTE || b == END_BYTE) && $urandom_range(0, 9) != 0)
                    b = b ^ 8'h80;
                if (!mode_manual && i == 0 && $urandom_range(0, 4) != 0)
                    b = 8'h30 + 8'($urandom_range(0, 9));
                if (!mode_manual && i > 0)
                    sum = sum + b;
                send_byte(b);
            end
            if (!mode_manual && n > 0)
            begin
                if (sum < CHECK_FLOOR)
                    sum = sum + CHECK_FLOOR;
                if (kind >= 12 && kind < 22)
                    sum = sum ^ (8'h01 << $urandom_range(0, 7));
                send_byte(sum);
            end
            if (kind < 22 || kind >= 26)
                send_byte(END_BYTE);
        end
    endtask

    task automatic random_traffic(input int target);
        int stop_at;
        stop_at = bytes_sent + target;
        while (bytes_sent < stop_at)
        begin
            send_random_frame(-1);
            if ($urandom_range(0, 39) == 0)
                wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // default settings: auto mode, checking on, echo off, limit 256
    task automatic test_auto_frames();
        // good frame, order digit not summed, checksum 0xFF
        send_byte(START_BYTE);
        send_byte(8'h31);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(END_BYTE);
        // restart mid-frame; sum 0x05 is raised to 0x25
        send_byte(START_BYTE);
        send_byte(8'h31);
        send_byte(START_BYTE);
        send_byte(8'h31);
        send_byte(8'h00);
        send_byte(8'h05);
        send_byte(8'h25);
        send_byte(END_BYTE);
        // end right after start: no checksum byte
        send_byte(START_BYTE);
        send_byte(END_BYTE);
        // wrong checksum
        send_byte(START_BYTE);
        send_byte(8'h31);
        send_byte(8'h41);
        send_byte(8'h42);
        send_byte(END_BYTE);
        // end byte with no frame open, then a frame with no start byte
        send_byte(END_BYTE);
        send_byte(8'h55);
        send_byte(8'h66);
        send_byte(END_BYTE);
        random_traffic(180);
    endtask

    // echo on, with a stretch where neither side idles
    task automatic test_echo();
        write_reg(CFG_ECHO_ENABLE, 9'd1);
        no_idle = 1'b1;
        random_traffic(120);
        no_idle = 1'b0;
        write_reg(CFG_ECHO_ENABLE, 9'd0);
    endtask

    task automatic test_skip_check();
        write_reg(CFG_SKIP_CHECK, 9'd1);
        // still fails: nothing to strip
        send_byte(START_BYTE);
        send_byte(END_BYTE);
        // wrong checksum passes
        send_byte(START_BYTE);
        send_byte(8'h31);
        send_byte(8'h41);
        send_byte(8'h99);
        send_byte(END_BYTE);
        random_traffic(120);
        write_reg(CFG_SKIP_CHECK, 9'd0);
    endtask

    task automatic test_manual_mode();
        write_reg(CFG_MANUAL_MODE, 9'd1);
        // held byte goes out with the end
        send_byte(START_BYTE);
        send_byte(8'h41);
        send_byte(8'h42);
        send_byte(END_BYTE);
        send_byte(START_BYTE);
        send_byte(END_BYTE);
        random_traffic(120);
        write_reg(CFG_MANUAL_MODE, 9'd0);
    endtask

    // limit values below, at and above the clamp range
    task automatic test_frame_limit();
        logic [8:0] lims[7] = '{9'd0, 9'd3, 9'd5, 9'd255, 9'd511, 9'd257, 9'd256};
        int         k;
        write_reg(CFG_FRAME_LIMIT, FRAME_LIMIT_MIN);
        // fourth byte of a frame overruns
        send_byte(START_BYTE);
        send_byte(8'h31);
        send_byte(8'h41);
        send_byte(8'h42);
        random_traffic(60);
        for (k = 0; k < 7; k++)
        begin
            write_reg(CFG_FRAME_LIMIT, lims[k]);
            // long frame against a limit just below the top and a clamped one
            if (lims[k] == 9'd255 || lims[k] == 9'd511)
                send_random_frame($urandom_range(250, 256));
            random_traffic(20);
        end
    endtask

    // random settings per phase; some phases change them mid-frame
    task automatic test_mixed_settings();
        int p;
        int k;
        for (p = 0; p < 8; p++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                send_byte(START_BYTE);
                for (k = $urandom_range(1, 4); k > 0; k--)
                    send_byte(8'h30 + 8'($urandom_range(0, 9)));
            end
            write_reg(CFG_MANUAL_MODE, 9'($urandom_range(0, 511)));
            write_reg(CFG_SKIP_CHECK, 9'($urandom_range(0, 511)));
            write_reg(CFG_ECHO_ENABLE, 9'($urandom_range(0, 511)));
            case ($urandom_range(0, 2))
                0: write_reg(CFG_FRAME_LIMIT, 9'($urandom_range(4, 20)));
                1: write_reg(CFG_FRAME_LIMIT, FRAME_LIMIT_MAX);
                default: write_reg(CFG_FRAME_LIMIT, 9'($urandom_range(0, 511)));
            endcase
            no_idle = (p == 3);
            random_traffic(15);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_auto_frames();
        test_echo();
        test_skip_check();
        test_manual_mode();
        test_frame_limit();
        test_mixed_settings();

        wait_drained();
        repeat (4) @(posedge clk);

        $display("sent %0d bytes, checked %0d words, %0d register writes",
                 bytes_sent, words_checked, cfg_writes);
        $display("frame ends: ok %0d, bad checksum %0d, no start %0d, overrun %0d",
                 status_count[0], status_count[1], status_count[2], status_count[3]);
        if (errors == 0)
            $display("frame_receiver_with_checksum_unit test passed");
        else
            $display("frame_receiver_with_checksum_unit test failed");
        $finish;
    end

endmodule
